FILE: hw/rtl/gfps_pkg.sv
package gfps_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned OPCODE_W      = 2;
    localparam int unsigned TIMEOUT_W     = 16;
    localparam int unsigned RETRY_W       = 4;
    localparam int unsigned PHASE_W       = 3;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned TIME_WIDTH_DEF = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(15 * 60);
    localparam logic [RETRY_W-1:0]   RETRY_RST   = RETRY_W'(4);
    localparam logic [RETRY_W-1:0]   RETRY_MAX   = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIX_TIMEOUT = 1'b0,
        CFG_MAX_RETRIES = 1'b1
    } t_cfg_index;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_EXEC  = 2'd2
    } t_opcode;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_POWERUP   = 3'd1,
        PH_POWERWAIT = 3'd2,
        PH_RXSTART   = 3'd3,
        PH_RXWAIT    = 3'd4,
        PH_RETRY     = 3'd5,
        PH_DONE      = 3'd6
    } t_phase;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] fix_timeout;
        logic [RETRY_W-1:0]   max_retries;
    } t_cfg;

    typedef struct packed {
        logic receiver_error;
        logic fix_valid;
        logic gga_received;
        logic power_on_error;
        logic power_on_ok;
    } t_flags;

    typedef struct packed {
        t_phase phase;
        logic   busy;
        logic   schedule_report;
        logic   uart_to_modem;
        logic   receiver_stop;
        logic   receiver_start;
        logic   power_down;
        logic   power_restart;
    } t_result;

endpackage

FILE: hw/rtl/gfps_cfg.sv
module gfps_cfg
    import gfps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [CFG_INDEX_W-1:0] i_index,
    input  logic [CFG_DATA_W-1:0]  i_data,
    output t_cfg                   o_cfg
);

    logic [TIMEOUT_W-1:0] r_timeout;
    logic [RETRY_W-1:0]   r_retries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_retries <= RETRY_RST;
        end else if (i_wr) begin
            case (t_cfg_index'(i_index))
                CFG_FIX_TIMEOUT: r_timeout <= i_data[TIMEOUT_W-1:0];
                CFG_MAX_RETRIES: r_retries <= i_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.fix_timeout = r_timeout;
    assign o_cfg.max_retries = r_retries;

endmodule

FILE: hw/rtl/gfps_step.sv
module gfps_step
    import gfps_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  t_flags                i_flags,
    input  t_cfg                  i_cfg,
    output t_result               o_res
);

    localparam int unsigned CMP_W = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;

    t_phase                r_phase, n_phase;
    logic                  r_active, n_active;
    logic [RETRY_W-1:0]    r_retry, n_retry;
    logic [TIME_WIDTH-1:0] r_start_time, n_start_time;

    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_timed_out;
    logic [RETRY_W-1:0]    w_retry_inc;
    logic                  w_run;
    t_phase                w_phase_in;

    assign w_elapsed   = i_now - r_start_time;
    assign w_timed_out = CMP_W'(w_elapsed) > CMP_W'(i_cfg.fix_timeout);
    assign w_retry_inc = (r_retry == RETRY_MAX) ? r_retry : r_retry + RETRY_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_active     = r_active;
        n_retry      = r_retry;
        n_start_time = r_start_time;
        o_res        = '0;
        w_run        = 1'b0;
        w_phase_in   = r_phase;

        case (t_opcode'(i_opcode))
            OP_START: begin
                if (!r_active) begin
                    // A start arms the block and runs the power-up phase at once.
                    n_active   = 1'b1;
                    n_retry    = '0;
                    w_run      = 1'b1;
                    w_phase_in = PH_POWERUP;
                end
            end
            OP_STOP: begin
                o_res.power_down    = 1'b1;
                o_res.receiver_stop = 1'b1;
                o_res.uart_to_modem = 1'b1;
                n_active            = 1'b0;
            end
            OP_EXEC: begin
                w_run = r_active;
            end
            default: ;
        endcase

        if (w_run) begin
            case (w_phase_in)
                PH_IDLE: ;
                PH_POWERUP: begin
                    o_res.power_restart = 1'b1;
                    n_phase             = PH_POWERWAIT;
                    n_start_time        = i_now;
                end
                PH_POWERWAIT: begin
                    if (i_flags.power_on_ok) begin
                        n_phase = PH_RXSTART;
                    end else if (i_flags.power_on_error) begin
                        n_phase = PH_RETRY;
                    end
                end
                PH_RXSTART: begin
                    o_res.receiver_start = 1'b1;
                    n_phase              = PH_RXWAIT;
                end
                PH_RXWAIT: begin
                    if (i_flags.gga_received) begin
                        if (i_flags.fix_valid || w_timed_out) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_RXSTART;
                        end
                    end else if (i_flags.receiver_error) begin
                        n_phase = PH_RETRY;
                    end
                end
                PH_RETRY: begin
                    o_res.power_down = 1'b1;
                    n_retry          = w_retry_inc;
                    n_phase = (w_retry_inc < i_cfg.max_retries) ? PH_POWERUP : PH_DONE;
                end
                default: begin
                    // Done, and any unused code, closes the run.
                    o_res.power_down      = 1'b1;
                    o_res.receiver_stop   = 1'b1;
                    o_res.uart_to_modem   = 1'b1;
                    o_res.schedule_report = 1'b1;
                    n_active              = 1'b0;
                    n_phase               = PH_IDLE;
                end
            endcase
        end

        o_res.busy  = n_active;
        o_res.phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_active     <= 1'b0;
            r_retry      <= '0;
            r_start_time <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_active     <= n_active;
            r_retry      <= n_retry;
            r_start_time <= n_start_time;
        end
    end

`ifndef SYNTHESIS
    a_stop_clears_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_opcode == OP_STOP) |=> !r_active)
        else $error("stop did not clear the active flag");

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_opcode == OP_START && !r_active)
        |=> (r_active && r_phase == PH_POWERWAIT && r_start_time == $past(i_now)))
        else $error("start did not arm the sequencer");

    a_active_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_phase != PH_IDLE)
        else $error("sequencer active in idle phase");

    a_retry_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !(i_opcode == OP_START && !r_active)) |=> r_retry >= $past(r_retry))
        else $error("retry count went down without a start");
`endif

endmodule

FILE: hw/rtl/gps_fix_power_sequencer_top.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: opcode; tdata: time and status flags
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: commands, busy, phase
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// An item is held in the input register and is then stepped into the result
// register; one item per cycle is sustained while the output is not stalled.
// The sequencer state updates as the item moves into the result register.
// Reset is synchronous and active low; config returns to its defaults.
// A stalled output holds its result; the input register takes an item only while empty.
module gps_fix_power_sequencer_top
    import gfps_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [TIME_WIDTH-1:0] now_seconds, then power_on_ok, power_on_error,
    // gga_received, fix_valid, receiver_error, zero padding
    input  logic [((TIME_WIDTH + 5 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [OPCODE_W-1:0]    s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] power_restart, [1] power_down, [2] receiver_start, [3] receiver_stop,
    // [4] uart_to_modem, [5] schedule_report, [6] busy_res, [9:7] phase, zero padding
    output logic [((7 + PHASE_W + 7) / 8) * 8 - 1:0] m_axis_tdata,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned OUT_BITS = 7 + PHASE_W;
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    logic                  r_in_valid;
    logic [OPCODE_W-1:0]   r_in_opcode;
    logic [TIME_WIDTH-1:0] r_in_now;
    t_flags                r_in_flags;

    logic                  r_out_valid;
    t_result               r_out_res;

    logic                  w_in_fire;
    logic                  w_step;
    t_cfg                  w_cfg;
    t_result               w_res;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_opcode               <= s_axis_tuser;
            r_in_now                  <= s_axis_tdata[TIME_WIDTH-1:0];
            r_in_flags.power_on_ok    <= s_axis_tdata[TIME_WIDTH];
            r_in_flags.power_on_error <= s_axis_tdata[TIME_WIDTH+1];
            r_in_flags.gga_received   <= s_axis_tdata[TIME_WIDTH+2];
            r_in_flags.fix_valid      <= s_axis_tdata[TIME_WIDTH+3];
            r_in_flags.receiver_error <= s_axis_tdata[TIME_WIDTH+4];
        end
    end

    gfps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    gfps_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_step),
        .i_opcode (r_in_opcode),
        .i_now    (r_in_now),
        .i_flags  (r_in_flags),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_res.phase,
                                   r_out_res.busy,
                                   r_out_res.schedule_report,
                                   r_out_res.uart_to_modem,
                                   r_out_res.receiver_stop,
                                   r_out_res.receiver_start,
                                   r_out_res.power_down,
                                   r_out_res.power_restart});

endmodule
